@@ rtl/qbdp_pkg.sv @@
// shared constants, types and command structs for the q4 block dot product
`timescale 1ns / 1ps

package qbdp_pkg;

   // elements per quantized block and bytes per block (two nibbles per byte)
   localparam int BLOCK_ELEMENTS  = 32;
   localparam int BYTES_PER_BLOCK = BLOCK_ELEMENTS / 2;

   // byte position counter width
   localparam int POS_W = (BYTES_PER_BLOCK > 1) ? $clog2(BYTES_PER_BLOCK) : 1;

   // field widths
   localparam int BYTE_W  = 8;
   localparam int NIB_W   = 4;
   localparam int SCALE_W = 16;
   localparam int ACT_W   = 16;
   localparam int ROW_W   = 48;
   localparam int IDX_W   = 16;

   // nibble offset and fixed point shift of the scaled block sum
   localparam int NIBBLE_BIAS = 8;
   localparam int SCALE_SHIFT = 12;

   // biased weight, one product, sum of the two products of a byte
   localparam int WEIGHT_W = NIB_W + 1;
   localparam int PROD1_W  = WEIGHT_W + ACT_W;
   localparam int PAIR_W   = PROD1_W;
   // block sum grows by log2 of the byte count
   localparam int BLOCK_ACC_W = PAIR_W + $clog2(BYTES_PER_BLOCK);
   // block sum times scale, then after the shift
   localparam int PROD_W = BLOCK_ACC_W + SCALE_W;
   localparam int TERM_W = PROD_W - SCALE_SHIFT;

   // commands from controller to datapath
   typedef struct packed {
      logic mac;     // transaction accepted: accumulate the byte
      logic scale;   // multiply the finished block sum by its scale
      logic row;     // add the scaled block into the row accumulator
      logic emit;    // load the result register and start a new row
   } dp_cmd_type;

   // status from datapath to controller
   typedef struct packed {
      logic block_end;   // the byte at the input completes a block
   } dp_status_type;

endpackage

@@ rtl/qbdp_ctrl.sv @@
// controller state machine: input acceptance, block and row sequencing, result valid
`timescale 1ns / 1ps

module qbdp_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   input  logic                   req_last_in_row,
   output logic                   req_stall,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   input  qbdp_pkg::dp_status_type status,
   output qbdp_pkg::dp_cmd_type    cmd
);

   typedef enum logic [1:0] {
      S_IDLE,
      S_SCALE,
      S_ROW,
      S_EMIT
   } state_type;

   state_type state_ff, state_in;
   logic      last_ff, last_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      accept;
   logic      out_free;

   assign accept    = req_valid && (state_ff == S_IDLE);
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign req_stall = (state_ff != S_IDLE);
   assign rsp_valid = rsp_valid_ff;

   // datapath commands
   always_comb begin
      cmd       = '0;
      cmd.mac   = accept;
      cmd.scale = (state_ff == S_SCALE);
      cmd.row   = (state_ff == S_ROW);
      cmd.emit  = (state_ff == S_EMIT) && out_free;
   end

   // next state
   always_comb begin
      state_in     = state_ff;
      last_in      = last_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               last_in = req_last_in_row;
               if (status.block_end) begin
                  state_in = S_SCALE;
               end else if (req_last_in_row) begin
                  state_in = S_EMIT;
               end
            end
         end
         S_SCALE: begin
            state_in = S_ROW;
         end
         S_ROW: begin
            state_in = last_ff ? S_EMIT : S_IDLE;
         end
         S_EMIT: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // state and registered outputs
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         last_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         last_ff      <= last_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

@@ rtl/qbdp_datapath.sv @@
// datapath: nibble products, block sum, scale multiply, saturating row sum, result register
`timescale 1ns / 1ps

module qbdp_datapath (
   input  logic                                  clock,
   input  logic                                  reset,
   input  qbdp_pkg::dp_cmd_type                   cmd,
   output qbdp_pkg::dp_status_type                status,
   input  logic        [qbdp_pkg::BYTE_W-1:0]     req_quant_byte,
   input  logic signed [qbdp_pkg::SCALE_W-1:0]    req_block_scale,
   input  logic signed [qbdp_pkg::ACT_W-1:0]      req_act_even,
   input  logic signed [qbdp_pkg::ACT_W-1:0]      req_act_odd,
   output logic signed [qbdp_pkg::ROW_W-1:0]      rsp_row_sum,
   output logic        [qbdp_pkg::IDX_W-1:0]      rsp_row_index,
   output logic                                  rsp_saturated
);

   localparam logic [qbdp_pkg::POS_W-1:0] POS_LAST =
      qbdp_pkg::POS_W'(qbdp_pkg::BYTES_PER_BLOCK - 1);
   localparam logic signed [qbdp_pkg::WEIGHT_W-1:0] BIAS =
      qbdp_pkg::WEIGHT_W'(qbdp_pkg::NIBBLE_BIAS);
   localparam logic signed [qbdp_pkg::ROW_W-1:0] ROW_MAX =
      {1'b0, {(qbdp_pkg::ROW_W-1){1'b1}}};
   localparam logic signed [qbdp_pkg::ROW_W-1:0] ROW_MIN =
      {1'b1, {(qbdp_pkg::ROW_W-1){1'b0}}};

   logic        [qbdp_pkg::POS_W-1:0]       pos_ff, pos_in;
   logic signed [qbdp_pkg::BLOCK_ACC_W-1:0] block_acc_ff, block_acc_in;
   logic signed [qbdp_pkg::SCALE_W-1:0]     scale_ff, scale_in;
   logic signed [qbdp_pkg::PROD_W-1:0]      prod_ff, prod_in;
   logic signed [qbdp_pkg::ROW_W-1:0]       row_acc_ff, row_acc_in;
   logic                                    clip_ff, clip_in;
   logic        [qbdp_pkg::IDX_W-1:0]       row_cnt_ff, row_cnt_in;
   logic signed [qbdp_pkg::ROW_W-1:0]       sum_out_ff, sum_out_in;
   logic        [qbdp_pkg::IDX_W-1:0]       idx_out_ff, idx_out_in;
   logic                                    sat_out_ff, sat_out_in;

   logic signed [qbdp_pkg::WEIGHT_W-1:0]    w_even, w_odd;
   logic signed [qbdp_pkg::PROD1_W-1:0]     p_even, p_odd;
   logic signed [qbdp_pkg::PAIR_W-1:0]      pair;
   logic signed [qbdp_pkg::TERM_W-1:0]      term;
   logic signed [qbdp_pkg::ROW_W:0]         row_sum_wide;
   logic                                    row_ovf;

   assign status.block_end = (pos_ff == POS_LAST);

   // nibble minus bias times activation, both halves of the byte
   always_comb begin
      w_even = $signed({1'b0, req_quant_byte[qbdp_pkg::NIB_W-1:0]}) - BIAS;
      w_odd  = $signed({1'b0, req_quant_byte[qbdp_pkg::BYTE_W-1:qbdp_pkg::NIB_W]}) - BIAS;
      p_even = w_even * req_act_even;
      p_odd  = w_odd * req_act_odd;
      pair   = p_even + p_odd;
   end

   // scaled block term, floor shift, then 49-bit add for the saturation check
   always_comb begin
      prod_in      = block_acc_ff * scale_ff;
      term         = qbdp_pkg::TERM_W'(prod_ff >>> qbdp_pkg::SCALE_SHIFT);
      row_sum_wide = (qbdp_pkg::ROW_W+1)'(row_acc_ff) + (qbdp_pkg::ROW_W+1)'(term);
      row_ovf      = row_sum_wide[qbdp_pkg::ROW_W] != row_sum_wide[qbdp_pkg::ROW_W-1];
   end

   // next values of the accumulators and result register
   always_comb begin
      pos_in       = pos_ff;
      block_acc_in = block_acc_ff;
      scale_in     = scale_ff;
      row_acc_in   = row_acc_ff;
      clip_in      = clip_ff;
      row_cnt_in   = row_cnt_ff;
      sum_out_in   = sum_out_ff;
      idx_out_in   = idx_out_ff;
      sat_out_in   = sat_out_ff;

      if (cmd.mac) begin
         block_acc_in = block_acc_ff + qbdp_pkg::BLOCK_ACC_W'(pair);
         scale_in     = req_block_scale;
         pos_in       = status.block_end ? '0 : pos_ff + 1'b1;
      end

      if (cmd.scale) begin
         block_acc_in = '0;
      end

      if (cmd.row) begin
         if (row_ovf) begin
            row_acc_in = row_sum_wide[qbdp_pkg::ROW_W] ? ROW_MIN : ROW_MAX;
            clip_in    = 1'b1;
         end else begin
            row_acc_in = row_sum_wide[qbdp_pkg::ROW_W-1:0];
         end
      end

      // row end: hand the sums to the result register and open a new row
      if (cmd.emit) begin
         sum_out_in   = row_acc_ff;
         idx_out_in   = row_cnt_ff;
         sat_out_in   = clip_ff;
         block_acc_in = '0;
         pos_in       = '0;
         row_acc_in   = '0;
         clip_in      = 1'b0;
         row_cnt_in   = row_cnt_ff + 1'b1;
      end
   end

   // running state
   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff       <= '0;
         block_acc_ff <= '0;
         row_acc_ff   <= '0;
         clip_ff      <= 1'b0;
         row_cnt_ff   <= '0;
      end else begin
         pos_ff       <= pos_in;
         block_acc_ff <= block_acc_in;
         row_acc_ff   <= row_acc_in;
         clip_ff      <= clip_in;
         row_cnt_ff   <= row_cnt_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      scale_ff   <= scale_in;
      sum_out_ff <= sum_out_in;
      idx_out_ff <= idx_out_in;
      sat_out_ff <= sat_out_in;
      if (cmd.scale) begin
         prod_ff <= prod_in;
      end
   end

   assign rsp_row_sum   = sum_out_ff;
   assign rsp_row_index = idx_out_ff;
   assign rsp_saturated = sat_out_ff;

endmodule

@@ rtl/q4_block_dot_product.sv @@
// top level of the q4 block dot product: controller, datapath and checks
//
//   channel | ports                                         | direction
//   req     | req_valid req_stall quant_byte block_scale ... | in, one packed weight byte
//   rsp     | rsp_valid rsp_stall row_sum row_index saturated| out, one per row
//
// a byte that does not complete a block is taken while the controller stays idle; a byte
// that completes a block runs the steps accumulate, scale multiply, saturating row add
// a row-ending byte adds a step that loads the result register, held while
// the previous result is still stalled there
// reset is synchronous and clears the state machine, the block and row sums and the row count
// the next row is accepted while a finished result waits in the output register
`timescale 1ns / 1ps

module q4_block_dot_product (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   output logic                                  req_stall,
   input  logic        [qbdp_pkg::BYTE_W-1:0]     req_quant_byte,
   input  logic signed [qbdp_pkg::SCALE_W-1:0]    req_block_scale,
   input  logic signed [qbdp_pkg::ACT_W-1:0]      req_act_even,
   input  logic signed [qbdp_pkg::ACT_W-1:0]      req_act_odd,
   input  logic                                  req_last_in_row,
   output logic                                  rsp_valid,
   input  logic                                  rsp_stall,
   output logic signed [qbdp_pkg::ROW_W-1:0]      rsp_row_sum,
   output logic        [qbdp_pkg::IDX_W-1:0]      rsp_row_index,
   output logic                                  rsp_saturated
);

   qbdp_pkg::dp_cmd_type    dp_cmd;
   qbdp_pkg::dp_status_type dp_status;

   // sequencing
   qbdp_ctrl u_ctrl (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_last_in_row (req_last_in_row),
      .req_stall       (req_stall),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .status          (dp_status),
      .cmd             (dp_cmd)
   );

   // arithmetic and result register
   qbdp_datapath u_datapath (
      .clock           (clock),
      .reset           (reset),
      .cmd             (dp_cmd),
      .status          (dp_status),
      .req_quant_byte  (req_quant_byte),
      .req_block_scale (req_block_scale),
      .req_act_even    (req_act_even),
      .req_act_odd     (req_act_odd),
      .rsp_row_sum     (rsp_row_sum),
      .rsp_row_index   (rsp_row_index),
      .rsp_saturated   (rsp_saturated)
   );

`ifndef ASSERT_OFF
   // a scale multiply is always followed by the row add
   a_scale_then_row: assert property (@(posedge clock) disable iff (reset)
      dp_cmd.scale |=> dp_cmd.row)
      else $error("scale step not followed by row add");

   // loading the result register always raises the result valid
   a_emit_valid: assert property (@(posedge clock) disable iff (reset)
      dp_cmd.emit |=> rsp_valid)
      else $error("result not presented after emit");

   // a new result appears only from an emit step
   a_valid_from_emit: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(dp_cmd.emit))
      else $error("result valid rose without emit");

   // no transaction is taken while a block or row is being finished
   a_no_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (dp_cmd.scale || dp_cmd.row) |-> req_stall)
      else $error("input taken during block finish");
`endif

endmodule
